// ----- rtl/tod_adj_pkg.sv -----
`default_nettype none

package tod_adj_pkg;

    // command codes
    localparam logic [2:0] MODE_ADD_SEC = 3'd0;
    localparam logic [2:0] MODE_SUB_SEC = 3'd1;
    localparam logic [2:0] MODE_ADD_MIN = 3'd2;
    localparam logic [2:0] MODE_SUB_MIN = 3'd3;
    localparam logic [2:0] MODE_ADD_HR  = 3'd4;
    localparam logic [2:0] MODE_SUB_HR  = 3'd5;
    localparam logic [2:0] MODE_LOAD    = 3'd6;
    localparam logic [2:0] MODE_CMP     = 3'd7;

    // time constants
    localparam int unsigned UNITS_PER_MIN = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned MAX_HOUR      = 23;
    localparam int unsigned MAX_MIN_SEC   = 59;
    localparam int unsigned NOON_HOUR     = 12;

    // reciprocals for division by constants
    // amount / 60 : (amount * 69906) >> 22, exact for 16-bit amount
    localparam logic [16:0] RECIP_60_WIDE   = 17'd69906;
    localparam int unsigned SHIFT_60_WIDE   = 22;
    // amount / 24 : (amount * 43691) >> 20, exact for 16-bit amount
    localparam logic [15:0] RECIP_24_WIDE   = 16'd43691;
    localparam int unsigned SHIFT_24_WIDE   = 20;
    // q / 60 : (q * 1093) >> 16, exact for q up to 1092
    localparam logic [10:0] RECIP_60_NARROW = 11'd1093;
    localparam int unsigned SHIFT_60_NARROW = 16;
    // q / 24 : (q * 1366) >> 15, exact for q up to 1092
    localparam logic [10:0] RECIP_24_NARROW = 11'd1366;
    localparam int unsigned SHIFT_24_NARROW = 15;

    // mixed-radix step applied to the time
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_delta;

endpackage

`default_nettype wire

// ----- rtl/time_of_day_adjust_counter_core.sv -----
// an accepted item passes the stage a, stage b and result registers before reaching the output
// throughput: one item per cycle unless the output stalls; the time update is a
// combinational carry/borrow chain over the hours, minutes and seconds registers
// stages: amount split by reciprocal multiply, delta per command, time update
// reset: synchronous active-low; clears the time to 00:00:00, display_12h to 0
// and empties the pipeline
`default_nettype none

module time_of_day_adjust_counter_core
    import tod_adj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_amount,
    input  wire logic [4:0]  i_new_hour,
    input  wire logic [5:0]  i_new_minute,
    input  wire logic [5:0]  i_new_second,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_hour_out,
    output logic [5:0]       o_minute_out,
    output logic [5:0]       o_second_out,
    output logic [4:0]       o_display_hour,
    output logic             o_is_pm,
    output logic             o_is_greater,
    output logic             o_is_equal,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    // ---------------------------------------------------------------
    // stage enables: each stage moves when empty or when the next moves
    // ---------------------------------------------------------------
    logic r_a_valid, r_b_valid;
    logic en_out, en_b, en_a;

    assign en_out     = !o_out_valid || !i_out_stall;
    assign en_b       = !r_b_valid || en_out;
    assign en_a       = !r_a_valid || en_b;
    assign o_in_stall = !en_a;
    assign o_cfg_ready = 1'b1;

    // configuration register
    logic r_display_12h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_12h <= 1'b0;
        end else if (i_cfg_valid) begin
            r_display_12h <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // stage a: split amount into amount/60, amount%60 and amount%24
    // ---------------------------------------------------------------
    logic [32:0] w_prod60;
    logic [10:0] w_q1;
    logic [15:0] w_q1x60;
    logic [15:0] w_r1_diff;
    logic [31:0] w_prod24;
    logic [11:0] w_q24;
    logic [15:0] w_q24x24;
    logic [15:0] w_m24_diff;

    assign w_prod60   = 33'(i_amount) * 33'(RECIP_60_WIDE);
    assign w_q1       = w_prod60[SHIFT_60_WIDE +: 11];
    assign w_q1x60    = 16'(w_q1) * 16'(UNITS_PER_MIN);
    assign w_r1_diff  = i_amount - w_q1x60;
    assign w_prod24   = 32'(i_amount) * 32'(RECIP_24_WIDE);
    assign w_q24      = w_prod24[SHIFT_24_WIDE +: 12];
    assign w_q24x24   = 16'(w_q24) * 16'(HOURS_PER_DAY);
    assign w_m24_diff = i_amount - w_q24x24;

    logic [2:0]  r_a_mode;
    logic [4:0]  r_a_oh;
    logic [5:0]  r_a_om;
    logic [5:0]  r_a_os;
    logic [10:0] r_a_q1;      // amount / 60
    logic [5:0]  r_a_r1;      // amount % 60
    logic [4:0]  r_a_m24;     // amount % 24

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in_valid) begin
            r_a_mode <= i_mode;
            r_a_oh   <= i_new_hour;
            r_a_om   <= i_new_minute;
            r_a_os   <= i_new_second;
            r_a_q1   <= w_q1;
            r_a_r1   <= w_r1_diff[5:0];
            r_a_m24  <= w_m24_diff[4:0];
        end
    end

    // ---------------------------------------------------------------
    // stage b: turn the amount into an hours/minutes/seconds delta
    // ---------------------------------------------------------------
    logic [21:0] w_prod_q2;
    logic [4:0]  w_q2;        // amount / 3600
    logic [10:0] w_q2x60;
    logic [10:0] w_r2_diff;   // (amount / 60) % 60
    logic [21:0] w_prod_qh;
    logic [5:0]  w_qh;
    logic [10:0] w_qhx24;
    logic [10:0] w_hm_diff;   // (amount / 60) % 24
    t_delta      w_delta;

    assign w_prod_q2 = 22'(r_a_q1) * 22'(RECIP_60_NARROW);
    assign w_q2      = w_prod_q2[SHIFT_60_NARROW +: 5];
    assign w_q2x60   = 11'(w_q2) * 11'(UNITS_PER_MIN);
    assign w_r2_diff = r_a_q1 - w_q2x60;
    assign w_prod_qh = 22'(r_a_q1) * 22'(RECIP_24_NARROW);
    assign w_qh      = w_prod_qh[SHIFT_24_NARROW +: 6];
    assign w_qhx24   = 11'(w_qh) * 11'(HOURS_PER_DAY);
    assign w_hm_diff = r_a_q1 - w_qhx24;

    always_comb begin
        unique case (r_a_mode)
            MODE_ADD_SEC, MODE_SUB_SEC: begin
                // amount is below one day, so no wrap is needed here
                w_delta.hour   = w_q2;
                w_delta.minute = w_r2_diff[5:0];
                w_delta.second = r_a_r1;
            end
            MODE_ADD_MIN, MODE_SUB_MIN: begin
                // amount % 1440 expressed as hours and minutes
                w_delta.hour   = w_hm_diff[4:0];
                w_delta.minute = r_a_r1;
                w_delta.second = 6'd0;
            end
            MODE_ADD_HR, MODE_SUB_HR: begin
                w_delta.hour   = r_a_m24;
                w_delta.minute = 6'd0;
                w_delta.second = 6'd0;
            end
            default: begin
                // load and compare take no delta
                w_delta = '0;
            end
        endcase
    end

    logic [2:0] r_b_mode;
    logic [4:0] r_b_oh;
    logic [5:0] r_b_om;
    logic [5:0] r_b_os;
    t_delta     r_b_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b_mode  <= r_a_mode;
            r_b_oh    <= r_a_oh;
            r_b_om    <= r_a_om;
            r_b_os    <= r_a_os;
            r_b_delta <= w_delta;
        end
    end

    // ---------------------------------------------------------------
    // stage c: update the time and build the result
    // ---------------------------------------------------------------
    logic [4:0] r_cur_hour;
    logic [5:0] r_cur_minute;
    logic [5:0] r_cur_second;

    // add path: carry seconds into minutes into hours
    logic [6:0] s_sum, m_sum;
    logic [5:0] h_sum;
    logic       c_s, c_m;
    logic [5:0] s_add, m_add;
    logic [4:0] h_add;

    assign s_sum = 7'(r_cur_second) + 7'(r_b_delta.second);
    assign c_s   = s_sum >= 7'(UNITS_PER_MIN);
    assign s_add = c_s ? 6'(s_sum - 7'(UNITS_PER_MIN)) : s_sum[5:0];
    assign m_sum = 7'(r_cur_minute) + 7'(r_b_delta.minute) + 7'(c_s);
    assign c_m   = m_sum >= 7'(UNITS_PER_MIN);
    assign m_add = c_m ? 6'(m_sum - 7'(UNITS_PER_MIN)) : m_sum[5:0];
    assign h_sum = 6'(r_cur_hour) + 6'(r_b_delta.hour) + 6'(c_m);
    assign h_add = (h_sum >= 6'(HOURS_PER_DAY)) ? 5'(h_sum - 6'(HOURS_PER_DAY)) : h_sum[4:0];

    // subtract path: borrow from minutes and hours, hours wrap by one day
    logic       b_s, b_m, b_h;
    logic [6:0] m_subtr;
    logic [5:0] h_subtr;
    logic [5:0] s_sub, m_sub;
    logic [4:0] h_sub;

    assign b_s     = r_cur_second < r_b_delta.second;
    assign s_sub   = 6'(7'(r_cur_second) + (b_s ? 7'(UNITS_PER_MIN) : 7'd0)
                        - 7'(r_b_delta.second));
    assign m_subtr = 7'(r_b_delta.minute) + 7'(b_s);
    assign b_m     = 7'(r_cur_minute) < m_subtr;
    assign m_sub   = 6'(7'(r_cur_minute) + (b_m ? 7'(UNITS_PER_MIN) : 7'd0) - m_subtr);
    assign h_subtr = 6'(r_b_delta.hour) + 6'(b_m);
    assign b_h     = 6'(r_cur_hour) < h_subtr;
    assign h_sub   = 5'(6'(r_cur_hour) + (b_h ? 6'(HOURS_PER_DAY) : 6'd0) - h_subtr);

    logic [4:0] n_cur_hour;
    logic [5:0] n_cur_minute;
    logic [5:0] n_cur_second;

    always_comb begin
        n_cur_hour   = r_cur_hour;
        n_cur_minute = r_cur_minute;
        n_cur_second = r_cur_second;
        unique case (r_b_mode)
            MODE_ADD_SEC, MODE_ADD_MIN, MODE_ADD_HR: begin
                n_cur_hour   = h_add;
                n_cur_minute = m_add;
                n_cur_second = s_add;
            end
            MODE_SUB_SEC, MODE_SUB_MIN, MODE_SUB_HR: begin
                n_cur_hour   = h_sub;
                n_cur_minute = m_sub;
                n_cur_second = s_sub;
            end
            MODE_LOAD: begin
                // each part loads only when its value is in range
                if (r_b_oh <= 5'(MAX_HOUR)) begin
                    n_cur_hour = r_b_oh;
                end
                if (r_b_om <= 6'(MAX_MIN_SEC)) begin
                    n_cur_minute = r_b_om;
                end
                if (r_b_os <= 6'(MAX_MIN_SEC)) begin
                    n_cur_second = r_b_os;
                end
            end
            MODE_CMP: begin
                // time left as it is
            end
            default: begin
            end
        endcase
    end

    // display hour: 12-hour form maps 0 and 12 to 12, 13..23 to 1..11
    logic [4:0] n_display_hour;

    always_comb begin
        if (!r_display_12h) begin
            n_display_hour = n_cur_hour;
        end else if (n_cur_hour > 5'(NOON_HOUR)) begin
            n_display_hour = n_cur_hour - 5'(NOON_HOUR);
        end else if (n_cur_hour == 5'd0) begin
            n_display_hour = 5'(NOON_HOUR);
        end else begin
            n_display_hour = n_cur_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_hour   <= 5'd0;
            r_cur_minute <= 6'd0;
            r_cur_second <= 6'd0;
            o_out_valid  <= 1'b0;
        end else if (en_out) begin
            o_out_valid <= r_b_valid;
            if (r_b_valid) begin
                r_cur_hour   <= n_cur_hour;
                r_cur_minute <= n_cur_minute;
                r_cur_second <= n_cur_second;
            end
        end
    end

    // result register; compare is lexicographic over hour, minute, second
    always_ff @(posedge i_clk) begin
        if (en_out && r_b_valid) begin
            o_hour_out     <= n_cur_hour;
            o_minute_out   <= n_cur_minute;
            o_second_out   <= n_cur_second;
            o_display_hour <= n_display_hour;
            o_is_pm        <= n_cur_hour >= 5'(NOON_HOUR);
            o_is_greater   <= {n_cur_hour, n_cur_minute, n_cur_second}
                              > {r_b_oh, r_b_om, r_b_os};
            o_is_equal     <= {n_cur_hour, n_cur_minute, n_cur_second}
                              == {r_b_oh, r_b_om, r_b_os};
        end
    end

endmodule

`default_nettype wire
